FILE: rtl/patan2_pkg.sv
// Shared constants and types for the pipelined polynomial atan2 block.
`timescale 1ns / 1ps

package patan2_pkg;

  // Default parameter values
  localparam int unsigned SAMPLE_WIDTH_DEF    = 16;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 13;

  // Output angle is always carried in 16 bits
  localparam int unsigned ANGLE_WIDTH = 16;

  // Ratio format: unsigned Q1.15, one quotient bit per divider step
  localparam int unsigned T_FRAC  = 15;
  localparam int unsigned T_WIDTH = 16;
  localparam logic [T_WIDTH-1:0] T_ONE = 16'd32768;

  // Divider partitioning
  localparam int unsigned DIV_BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES         = T_WIDTH / DIV_BITS_PER_STAGE;

  // Polynomial arithmetic in Q30
  localparam int unsigned Q30_FRAC = 30;
  localparam int unsigned T2_W     = 31;
  localparam int unsigned C7_W     = 26;
  localparam int unsigned P_W      = 28;
  localparam int unsigned M_W      = 29;
  localparam int unsigned A_W      = 31;
  localparam int unsigned REFL_W   = 32;

  localparam logic [C7_W-1:0]   C7_Q30   = 26'd49925210;
  localparam logic [P_W-1:0]    C5_Q30   = 28'd171062341;
  localparam logic [M_W-1:0]    C3_Q30   = 29'd351782264;
  localparam logic [REFL_W-1:0] PI_Q30   = 32'd3373259426;
  localparam logic [REFL_W-1:0] PIH_Q30  = 32'd1686629713;
  localparam logic [29:0]       HALF_Q30 = 30'd536870912;

  // Product widths
  localparam int unsigned PROD7_W = C7_W + T2_W;
  localparam int unsigned PRODP_W = P_W + T2_W;
  localparam int unsigned PRODM_W = M_W + T2_W;
  localparam int unsigned PRODU_W = M_W + T_WIDTH;

  // Per-item control flags that ride along the pipeline
  typedef struct packed {
    logic zero;   // both samples zero
    logic swap;   // |y| > |x|, reflect about pi/2
    logic xneg;   // reflect about pi
    logic yneg;   // negate result
  } flags_t;

endpackage

FILE: rtl/polynomial_atan2.sv
// Pipelined four-quadrant atan2 using a divider and a seventh-order polynomial.
`timescale 1ns / 1ps

// Usage:
//   Input channel (valid_i / ready_o) takes a signed sample pair y_sample_i,
//   x_sample_i. Output channel (valid_o / ready_i) delivers angle_o, signed
//   Q2.13 radians by default (pi = 25736), rounded and saturated to +-pi.
//   One result per accepted item, in order.
// Pipeline: DIV_STAGES + 12 register stages, 20 with the default parameters.
// Throughput: one item per cycle while ready_i is high or any stage is empty.
//   The ratio comes from a restoring divider that resolves two quotient
//   bits per stage, followed by one stage per multiply and one per
//   rounding step of the polynomial.
// Stall: while ready_i is low the last stage holds its result; earlier
//   stages keep moving into empty slots, so ready_o stays high until every
//   stage holds an item.
// Reset: rst_ni clears all stage valid bits; the pipeline comes up empty
//   and ready.
module polynomial_atan2 #(
  parameter int unsigned SAMPLE_WIDTH    = patan2_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = patan2_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]         y_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]         x_sample_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic signed [patan2_pkg::ANGLE_WIDTH-1:0] angle_o
);

  import patan2_pkg::*;

  // Stage indices
  localparam int unsigned ST_SORT = 0;
  localparam int unsigned ST_SQ   = DIV_STAGES + 1;
  localparam int unsigned ST_M7   = DIV_STAGES + 2;
  localparam int unsigned ST_P    = DIV_STAGES + 3;
  localparam int unsigned ST_MP   = DIV_STAGES + 4;
  localparam int unsigned ST_M    = DIV_STAGES + 5;
  localparam int unsigned ST_MM   = DIV_STAGES + 6;
  localparam int unsigned ST_U    = DIV_STAGES + 7;
  localparam int unsigned ST_MU   = DIV_STAGES + 8;
  localparam int unsigned ST_A    = DIV_STAGES + 9;
  localparam int unsigned ST_R    = DIV_STAGES + 10;
  localparam int unsigned ST_OUT  = DIV_STAGES + 11;
  localparam int unsigned NS      = DIV_STAGES + 12;

  localparam int unsigned NUM_W = SAMPLE_WIDTH + T_WIDTH;

  // Output rounding
  localparam int unsigned   SHIFT    = Q30_FRAC - ANGLE_FRAC_BITS;
  localparam logic [32:0]   HALF_OUT = 33'd1 << (29 - ANGLE_FRAC_BITS);
  localparam logic [32:0]   PI_OUT   = ({1'b0, PI_Q30} + HALF_OUT) >> SHIFT;

  // ---------------------------------------------------------------------
  // Stage valid bits and enables
  // ---------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // A stage may load when ready_i is high or it or any later stage holds a bubble
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ready_i || !(&v_q[NS-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  // ---------------------------------------------------------------------
  // Sort stage: magnitudes, ordering, dividend
  // ---------------------------------------------------------------------
  logic [SAMPLE_WIDTH-1:0] ay, ax, lo, hi;
  logic [NUM_W-1:0]        num;
  flags_t                  flg_sort;

  always_comb begin
    flg_sort.yneg = y_sample_i[SAMPLE_WIDTH-1];
    flg_sort.xneg = x_sample_i[SAMPLE_WIDTH-1];
    ay = flg_sort.yneg ? (~y_sample_i + 1'b1) : y_sample_i;
    ax = flg_sort.xneg ? (~x_sample_i + 1'b1) : x_sample_i;
    flg_sort.swap = ay > ax;
    flg_sort.zero = (ay == '0) && (ax == '0);
    lo  = flg_sort.swap ? ax : ay;
    hi  = flg_sort.swap ? ay : ax;
    num = {lo, {T_FRAC{1'b0}}} + NUM_W'(hi >> 1);
  end

  logic [SAMPLE_WIDTH-1:0] srem_q;
  logic [T_WIDTH-1:0]      snum_q;
  logic [SAMPLE_WIDTH-1:0] shi_q;
  flags_t                  sflg_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_SORT]) begin
      srem_q <= num[NUM_W-1:T_WIDTH];
      snum_q <= num[T_WIDTH-1:0];
      shi_q  <= hi;
      sflg_q <= flg_sort;
    end
  end

  // ---------------------------------------------------------------------
  // Restoring divider, DIV_BITS_PER_STAGE quotient bits per stage
  // ---------------------------------------------------------------------
  logic [SAMPLE_WIDTH-1:0] drem_q [DIV_STAGES];
  logic [T_WIDTH-1:0]      dnum_q [DIV_STAGES];
  logic [T_WIDTH-1:0]      dquo_q [DIV_STAGES];
  logic [SAMPLE_WIDTH-1:0] dhi_q  [DIV_STAGES];
  flags_t                  dflg_q [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    logic [SAMPLE_WIDTH-1:0] rem_in, rem_out, hi_in;
    logic [T_WIDTH-1:0]      num_in, num_out, quo_in, quo_out;
    flags_t                  flg_in;

    if (i == 0) begin : g_first
      assign rem_in = srem_q;
      assign num_in = snum_q;
      assign quo_in = '0;
      assign hi_in  = shi_q;
      assign flg_in = sflg_q;
    end else begin : g_next
      assign rem_in = drem_q[i-1];
      assign num_in = dnum_q[i-1];
      assign quo_in = dquo_q[i-1];
      assign hi_in  = dhi_q[i-1];
      assign flg_in = dflg_q[i-1];
    end

    always_comb begin
      logic [SAMPLE_WIDTH:0] r_ext;
      logic                  ge;
      rem_out = rem_in;
      num_out = num_in;
      quo_out = quo_in;
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
        r_ext = {rem_out, num_out[T_WIDTH-1]};
        ge    = r_ext >= {1'b0, hi_in};
        if (ge) begin
          r_ext = r_ext - {1'b0, hi_in};
        end
        rem_out = r_ext[SAMPLE_WIDTH-1:0];
        num_out = {num_out[T_WIDTH-2:0], 1'b0};
        quo_out = {quo_out[T_WIDTH-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_SORT+1+i]) begin
        drem_q[i] <= rem_out;
        dnum_q[i] <= num_out;
        dquo_q[i] <= quo_out;
        dhi_q[i]  <= hi_in;
        dflg_q[i] <= flg_in;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Polynomial
  // ---------------------------------------------------------------------
  logic [T_WIDTH-1:0] t_div;
  assign t_div = (dquo_q[DIV_STAGES-1] > T_ONE) ? T_ONE : dquo_q[DIV_STAGES-1];

  // t and t^2
  logic [T_WIDTH-1:0] sq_t_q;
  logic [T2_W-1:0]    sq_t2_q;
  flags_t             sq_flg_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_SQ]) begin
      sq_t_q   <= t_div;
      sq_t2_q  <= T2_W'(32'(t_div) * 32'(t_div));
      sq_flg_q <= dflg_q[DIV_STAGES-1];
    end
  end

  // c7 * t^2
  logic [T_WIDTH-1:0] m7_t_q;
  logic [T2_W-1:0]    m7_t2_q;
  logic [PROD7_W-1:0] m7_prod_q;
  flags_t             m7_flg_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_M7]) begin
      m7_t_q    <= sq_t_q;
      m7_t2_q   <= sq_t2_q;
      m7_prod_q <= PROD7_W'(sq_t2_q) * PROD7_W'(C7_Q30);
      m7_flg_q  <= sq_flg_q;
    end
  end

  // p = c5 - round(c7 * t^2)
  logic [PROD7_W:0]   r7;
  logic [T_WIDTH-1:0] p_t_q;
  logic [T2_W-1:0]    p_t2_q;
  logic [P_W-1:0]     p_q;
  flags_t             p_flg_q;

  assign r7 = {1'b0, m7_prod_q} + (PROD7_W+1)'(HALF_Q30);

  always_ff @(posedge clk_i) begin
    if (en[ST_P]) begin
      p_t_q   <= m7_t_q;
      p_t2_q  <= m7_t2_q;
      p_q     <= C5_Q30 - r7[Q30_FRAC+P_W-1:Q30_FRAC];
      p_flg_q <= m7_flg_q;
    end
  end

  // p * t^2
  logic [T_WIDTH-1:0] mp_t_q;
  logic [T2_W-1:0]    mp_t2_q;
  logic [PRODP_W-1:0] mp_prod_q;
  flags_t             mp_flg_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_MP]) begin
      mp_t_q    <= p_t_q;
      mp_t2_q   <= p_t2_q;
      mp_prod_q <= PRODP_W'(p_q) * PRODP_W'(p_t2_q);
      mp_flg_q  <= p_flg_q;
    end
  end

  // m = c3 - round(p * t^2)
  logic [PRODP_W:0]   rp;
  logic [T_WIDTH-1:0] m_t_q;
  logic [T2_W-1:0]    m_t2_q;
  logic [M_W-1:0]     m_q;
  flags_t             m_flg_q;

  assign rp = {1'b0, mp_prod_q} + (PRODP_W+1)'(HALF_Q30);

  always_ff @(posedge clk_i) begin
    if (en[ST_M]) begin
      m_t_q   <= mp_t_q;
      m_t2_q  <= mp_t2_q;
      m_q     <= C3_Q30 - M_W'(rp[Q30_FRAC+P_W-1:Q30_FRAC]);
      m_flg_q <= mp_flg_q;
    end
  end

  // m * t^2
  logic [T_WIDTH-1:0] mm_t_q;
  logic [PRODM_W-1:0] mm_prod_q;
  flags_t             mm_flg_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_MM]) begin
      mm_t_q    <= m_t_q;
      mm_prod_q <= PRODM_W'(m_q) * PRODM_W'(m_t2_q);
      mm_flg_q  <= m_flg_q;
    end
  end

  // u = round(m * t^2)
  logic [PRODM_W:0]   rm;
  logic [T_WIDTH-1:0] u_t_q;
  logic [M_W-1:0]     u_q;
  flags_t             u_flg_q;

  assign rm = {1'b0, mm_prod_q} + (PRODM_W+1)'(HALF_Q30);

  always_ff @(posedge clk_i) begin
    if (en[ST_U]) begin
      u_t_q   <= mm_t_q;
      u_q     <= rm[Q30_FRAC+M_W-1:Q30_FRAC];
      u_flg_q <= mm_flg_q;
    end
  end

  // u * t
  logic [T_WIDTH-1:0] mu_t_q;
  logic [PRODU_W-1:0] mu_prod_q;
  flags_t             mu_flg_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_MU]) begin
      mu_t_q    <= u_t_q;
      mu_prod_q <= PRODU_W'(u_q) * PRODU_W'(u_t_q);
      mu_flg_q  <= u_flg_q;
    end
  end

  // a = t - round(u * t), atan(t) in Q30
  logic [PRODU_W:0] ru;
  logic [A_W-1:0]   a_q;
  flags_t           a_flg_q;

  assign ru = {1'b0, mu_prod_q} + (PRODU_W+1)'(1 << (T_FRAC - 1));

  always_ff @(posedge clk_i) begin
    if (en[ST_A]) begin
      a_q     <= A_W'({mu_t_q, {T_FRAC{1'b0}}}) - A_W'(ru[T_FRAC+M_W-1:T_FRAC]);
      a_flg_q <= mu_flg_q;
    end
  end

  // ---------------------------------------------------------------------
  // Reflect into the right octant and add the rounding half
  // ---------------------------------------------------------------------
  logic [REFL_W-1:0] a1, a2;
  logic [32:0]       ang_q;
  flags_t            r_flg_q;

  always_comb begin
    a1 = a_flg_q.swap ? (PIH_Q30 - REFL_W'(a_q)) : REFL_W'(a_q);
    a2 = a_flg_q.xneg ? (PI_Q30 - a1) : a1;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_R]) begin
      ang_q   <= {1'b0, a2} + HALF_OUT;
      r_flg_q <= a_flg_q;
    end
  end

  // ---------------------------------------------------------------------
  // Scale, saturate, apply sign, force zero for a zero pair
  // ---------------------------------------------------------------------
  logic [32:0]            mag;
  logic [ANGLE_WIDTH-1:0] angle_q;

  always_comb begin
    mag = ang_q >> SHIFT;
    if (mag > PI_OUT) begin
      mag = PI_OUT;
    end
    if (r_flg_q.yneg) begin
      mag = ~mag + 1'b1;
    end
    if (r_flg_q.zero) begin
      mag = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      angle_q <= mag[ANGLE_WIDTH-1:0];
    end
  end

  assign angle_o = angle_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A full pipeline with a stalled receiver must refuse new items
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !ready_i) |-> !ready_o)
    else $error("input accepted while pipeline full and stalled");

  // Quotient never exceeds one for a nonzero pair
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[DIV_STAGES] && !dflg_q[DIV_STAGES-1].zero) |->
      (dquo_q[DIV_STAGES-1] <= T_ONE))
    else $error("divider ratio above one");

  // Reflected angle stays within pi plus the rounding half
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_R] && !r_flg_q.zero) |-> (ang_q <= ({1'b0, PI_Q30} + HALF_OUT)))
    else $error("reflected angle out of range");

endmodule
